@@ rtl/core/bpa_pkg.sv @@
// Shared constants, codes and transaction types for the bitmap page allocator.
// No dependencies; the sequencer, the top level and the checker use it by scoped names.
`default_nettype none

package bpa_pkg;

   // Map geometry. Both sizes are powers of two.
   localparam int NUM_PAGES  = 4096;
   localparam int PAGE_BYTES = 4096;

   localparam int ADDR_W     = 48;
   localparam int LEN_W      = 32;
   localparam int FCNT_W     = 13;
   localparam int IDX_W      = $clog2(NUM_PAGES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
   localparam int LSUM_W     = LEN_W + 1;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_ZERO_LEN = 2'd2
   } status_type;

   typedef struct packed {
      kind_type              kind;
      logic [LEN_W-1:0]      byte_length;
      logic [ADDR_W-1:0]     free_address;
      logic [FCNT_W-1:0]     free_pages;
   } request_type;

   typedef struct packed {
      status_type            status;
      logic [ADDR_W-1:0]     address;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/bpa_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/bpa_seq.sv @@
// Map sequencer: clear pass, first-fit scan, run marking and page freeing.
// Depends on bpa_pkg and bpa_ram (the used-bit map, one page per entry).
`default_nettype none

module bpa_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire bpa_pkg::request_type       req,
   input  wire logic [bpa_pkg::ADDR_W-1:0] base,
   output logic                            busy,
   output logic                            res_valid,
   output bpa_pkg::result_type             res,
   input  wire logic                       res_ready
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FREE,
      ST_DONE
   } state_type;

   localparam int IDX_W  = bpa_pkg::IDX_W;
   localparam int CNT_W  = bpa_pkg::CNT_W;
   localparam int ADDR_W = bpa_pkg::ADDR_W;
   localparam int SHIFT  = bpa_pkg::PAGE_SHIFT;
   localparam int PFN_W  = bpa_pkg::PFN_W;
   localparam int LSUM_W = bpa_pkg::LSUM_W;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            ptr_ff, ptr_in;
   logic                        eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]            eval_ptr_ff, eval_ptr_in;
   logic [CNT_W-1:0]            run_ff, run_in;
   logic [CNT_W-1:0]            pages_ff, pages_in;
   logic [IDX_W-1:0]            mark_ptr_ff, mark_ptr_in;
   logic [IDX_W-1:0]            mark_last_ff, mark_last_in;
   logic [ADDR_W-1:0]           faddr_ff, faddr_in;
   logic [bpa_pkg::FCNT_W-1:0]  fcnt_ff, fcnt_in;
   bpa_pkg::status_type         status_ff, status_in;
   logic [ADDR_W-1:0]           addr_ff, addr_in;

   logic                        ram_we;
   logic [IDX_W-1:0]            ram_addr;
   logic                        ram_wdata;
   logic                        ram_rdata;

   logic [LSUM_W-1:0]           len_sum;
   logic [LSUM_W-1:0]           pages_full;
   logic                        too_big;
   logic                        issue;
   logic [CNT_W-1:0]            run_inc;
   logic                        hit;
   logic                        last;
   logic [CNT_W-1:0]            start_wide;
   logic [IDX_W-1:0]            start_page;
   logic [ADDR_W:0]             diff;
   logic                        in_range;

   bpa_ram #(
      .WIDTH (1),
      .DEPTH (bpa_pkg::NUM_PAGES)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Rounded-up page count of an allocate request.
   assign len_sum    = LSUM_W'(req.byte_length) + LSUM_W'(bpa_pkg::PAGE_BYTES - 1);
   assign pages_full = len_sum >> SHIFT;
   assign too_big    = pages_full > LSUM_W'(bpa_pkg::NUM_PAGES);

   // Scan datapath: the page read last cycle is evaluated now.
   assign issue      = ptr_ff < CNT_W'(bpa_pkg::NUM_PAGES);
   assign run_inc    = run_ff + 1'b1;
   assign hit        = eval_vld_ff && !ram_rdata && (run_inc == pages_ff);
   assign last       = eval_vld_ff && (eval_ptr_ff == IDX_W'(bpa_pkg::NUM_PAGES - 1));
   assign start_wide = CNT_W'(eval_ptr_ff) + 1'b1 - pages_ff;
   assign start_page = start_wide[IDX_W-1:0];

   // Free datapath: page index of the current byte address.
   assign diff     = {1'b0, faddr_ff} - {1'b0, base};
   assign in_range = !diff[ADDR_W]
                  && (diff[ADDR_W-1:SHIFT] < PFN_W'(bpa_pkg::NUM_PAGES));

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = 1'b0;
      ram_addr  = ptr_ff[IDX_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
            ram_addr  = mark_ptr_ff;
         end
         ST_FREE: begin
            ram_we   = (fcnt_ff != '0) && in_range;
            ram_addr = diff[SHIFT+IDX_W-1:SHIFT];
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      eval_vld_in  = eval_vld_ff;
      eval_ptr_in  = eval_ptr_ff;
      run_in       = run_ff;
      pages_in     = pages_ff;
      mark_ptr_in  = mark_ptr_ff;
      mark_last_in = mark_last_ff;
      faddr_in     = faddr_ff;
      fcnt_in      = fcnt_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == CNT_W'(bpa_pkg::NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req.kind == bpa_pkg::KIND_FREE) begin
                  faddr_in = req.free_address;
                  fcnt_in  = req.free_pages;
                  state_in = ST_FREE;
               end else if (req.byte_length == '0) begin
                  status_in = bpa_pkg::STATUS_ZERO_LEN;
                  addr_in   = '0;
                  state_in  = ST_DONE;
               end else if (too_big) begin
                  status_in = bpa_pkg::STATUS_NO_FIT;
                  addr_in   = '0;
                  state_in  = ST_DONE;
               end else begin
                  pages_in    = pages_full[CNT_W-1:0];
                  ptr_in      = '0;
                  eval_vld_in = 1'b0;
                  run_in      = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            eval_vld_in = issue;
            eval_ptr_in = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (eval_vld_ff) begin
               run_in = ram_rdata ? '0 : run_inc;
            end
            if (hit) begin
               mark_ptr_in  = start_page;
               mark_last_in = eval_ptr_ff;
               status_in    = bpa_pkg::STATUS_OK;
               addr_in      = base + (ADDR_W'(start_page) << SHIFT);
               state_in     = ST_MARK;
            end else if (last) begin
               status_in = bpa_pkg::STATUS_NO_FIT;
               addr_in   = '0;
               state_in  = ST_DONE;
            end
         end
         ST_MARK: begin
            mark_ptr_in = mark_ptr_ff + 1'b1;
            if (mark_ptr_ff == mark_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_FREE: begin
            if (fcnt_ff == '0) begin
               status_in = bpa_pkg::STATUS_OK;
               addr_in   = '0;
               state_in  = ST_DONE;
            end else begin
               fcnt_in  = fcnt_ff - 1'b1;
               faddr_in = faddr_ff + ADDR_W'(bpa_pkg::PAGE_BYTES);
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         ptr_ff      <= '0;
         eval_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         eval_vld_ff <= eval_vld_in;
      end
      eval_ptr_ff  <= eval_ptr_in;
      run_ff       <= run_in;
      pages_ff     <= pages_in;
      mark_ptr_ff  <= mark_ptr_in;
      mark_last_ff <= mark_last_in;
      faddr_ff     <= faddr_in;
      fcnt_ff      <= fcnt_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
   end

   assign busy        = state_ff != ST_IDLE;
   assign res_valid   = state_ff == ST_DONE;
   assign res.status  = status_ff;
   assign res.address = addr_ff;

endmodule

`default_nettype wire

@@ rtl/core/bitmap_page_allocator.sv @@
// Top level of the first-fit bitmap page allocator.
// Depends on bpa_pkg and bpa_seq; holds the region base register and the result register.
//
// The block keeps one used bit per page of a region of NUM_PAGES pages of
// PAGE_BYTES bytes starting at region_base. An allocate transaction rounds
// byte_length up to whole pages, takes the lowest run of that many free pages
// that lies wholly inside the map, marks it used and answers with its start
// address; a free transaction clears free_pages pages starting at the page
// that holds free_address, skipping pages outside the map. The map lives in a
// single-port RAM walked one page per cycle. One transaction is in work at a
// time: req_stall is high from acceptance until its result moves to the
// output register, which then waits for the consumer while the next
// transaction starts. After reset the map is cleared page by page with
// req_stall high.
// Write region_base only while no transaction is in work.
`default_nettype none

module bitmap_page_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_kind,
   input  wire logic [bpa_pkg::LEN_W-1:0]   req_byte_length,
   input  wire logic [bpa_pkg::ADDR_W-1:0]  req_free_address,
   input  wire logic [bpa_pkg::FCNT_W-1:0]  req_free_pages,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [bpa_pkg::ADDR_W-1:0]       rsp_result_address,
   // region base register
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bpa_pkg::ADDR_W-1:0]  csr_region_base
);

   logic [bpa_pkg::ADDR_W-1:0] base_ff;
   logic                       out_full_ff;
   bpa_pkg::result_type        out_ff;

   bpa_pkg::request_type       req;
   bpa_pkg::result_type        res;
   logic                       busy;
   logic                       res_valid;
   logic                       res_ready;
   logic                       start;
   logic                       rsp_take;

   // Pack the request fields for the sequencer.
   assign req.kind         = bpa_pkg::kind_type'(req_kind);
   assign req.byte_length  = req_byte_length;
   assign req.free_address = req_free_address;
   assign req.free_pages   = req_free_pages;

   assign req_stall = busy;
   assign start     = req_valid && !busy;

   bpa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .base      (base_ff),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // The register is always ready; software must write it only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid) begin
         base_ff <= csr_region_base;
      end
   end

   // Output register: refill when empty or when the held transaction leaves.
   assign rsp_take  = out_full_ff && !rsp_stall;
   assign res_ready = !out_full_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         out_full_ff <= 1'b1;
      end else if (rsp_take) begin
         out_full_ff <= 1'b0;
      end
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_full_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_result_address = out_ff.address;

endmodule

`default_nettype wire

@@ rtl/core/bpa_checker.sv @@
// Port-level assertions for bitmap_page_allocator, bound to the top level.
// Depends on bpa_pkg for the status codes.
`default_nettype none

module bpa_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [1:0]                 rsp_status,
   input wire logic [bpa_pkg::ADDR_W-1:0] rsp_result_address
);

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_result_address))
      else $error("stalled response changed");

   // A failed or zero-length allocate answers address zero.
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bpa_pkg::STATUS_OK) |-> rsp_result_address == '0)
      else $error("non-ok response carries an address");

   // One transaction at a time: stall right after an acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in work");

   // Stall right after reset, when the map clear pass begins.
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open right after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_result_address (rsp_result_address)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for bitmap_page_allocator: directed table, then random phases.
// Depends on bpa_pkg and the block's RTL only; predicts responses with its own page map, but for typed rows.
`timescale 1ns / 100ps

module testbench;
   import bpa_pkg::*;

   // Longest quiet stretch that a correct block can produce: the clearing pass
   // after reset, or an allocate that scans and then marks the whole map, or a
   // free of the widest page count, plus a few stalls. Take it several times over.
   localparam int WATCHDOG_LIMIT = 10 * NUM_PAGES + 1000;
   localparam int DRAIN_CYCLES   = 32;

   typedef struct {
      int first;
      int count;
   } page_run;

   typedef struct {
      request_type req;
      bit          typed;
      result_type  want;
   } stimulus_row;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_ALLOC;
   logic [LEN_W-1:0]    req_byte_length = '0;
   logic [ADDR_W-1:0]   req_free_address = '0;
   logic [FCNT_W-1:0]   req_free_pages = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [ADDR_W-1:0]   rsp_result_address;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ADDR_W-1:0]   csr_region_base = '0;

   // Predictor state: one used bit per page and our copy of the region base.
   bit [NUM_PAGES-1:0]  page_used;
   logic [ADDR_W-1:0]   base_model;

   result_type          pending_results[$];
   page_run             live_runs[$];
   stimulus_row         directed_rows[$];

   int                  failures = 0;
   int                  idle_cycles = 0;
   int                  stall_left = 0;
   bit                  quiet = 1'b0;
   result_type          oldest;

   bitmap_page_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_byte_length    (req_byte_length),
      .req_free_address   (req_free_address),
      .req_free_pages     (req_free_pages),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_region_base    (csr_region_base)
   );

   always #4 clock = ~clock;

   // First fit: round the length up to pages, take the lowest run of free pages
   // that ends inside the map, mark it used and answer with its address.
   function automatic result_type allocate_pages(input logic [LEN_W-1:0] len);
      result_type        res;
      longint unsigned   want;
      longint unsigned   run;
      int                start;
      logic [ADDR_W-1:0] offset;
      res.status  = STATUS_OK;
      res.address = '0;
      if (len == 0) begin
         res.status = STATUS_ZERO_LEN;
         return res;
      end
      want = len;
      want = (want + PAGE_BYTES - 1) / PAGE_BYTES;
      run  = 0;
      if (want <= NUM_PAGES) begin
         for (int p = 0; p < NUM_PAGES; p++) begin
            if (page_used[p]) begin
               run = 0;
            end else begin
               run++;
               if (run == want) begin
                  start = p + 1 - int'(want);
                  for (int k = start; k <= p; k++)
                     page_used[k] = 1'b1;
                  // The address wraps at 48 bits when the base sits near the top.
                  offset      = ADDR_W'(start * PAGE_BYTES);
                  res.address = base_model + offset;
                  live_runs.push_back('{start, int'(want)});
                  return res;
               end
            end
         end
      end
      res.status = STATUS_NO_FIT;
      return res;
   endfunction

   // Clear the pages one by one; a page below the base or past the end of the
   // map is skipped. Freeing always answers ok with a zero address.
   function automatic result_type release_pages(input logic [ADDR_W-1:0] addr,
                                                input logic [FCNT_W-1:0] count);
      result_type        res;
      logic [ADDR_W-1:0] page_addr;
      logic [ADDR_W-1:0] idx;
      res.status  = STATUS_OK;
      res.address = '0;
      for (int i = 0; i < int'(count); i++) begin
         page_addr = addr + ADDR_W'(i * PAGE_BYTES);
         if (page_addr >= base_model) begin
            idx = (page_addr - base_model) / PAGE_BYTES;
            if (idx < NUM_PAGES)
               page_used[idx] = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic void add_row(input kind_type k, input logic [LEN_W-1:0] len,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic [FCNT_W-1:0] cnt, input bit typed,
                                   input status_type st, input logic [ADDR_W-1:0] res_addr);
      stimulus_row r;
      r.req.kind         = k;
      r.req.byte_length  = len;
      r.req.free_address = addr;
      r.req.free_pages   = cnt;
      r.typed            = typed;
      r.want.status      = st;
      r.want.address     = res_addr;
      directed_rows.push_back(r);
   endfunction

   // Mostly well-formed traffic: allocate small runs, free runs that are live,
   // with a share of zero lengths, oversized lengths and stray frees.
   function automatic request_type random_request();
      request_type r;
      page_run     sel;
      int          pick;
      int          n;
      int          j;
      r.kind         = KIND_ALLOC;
      r.byte_length  = $urandom;
      r.free_address = ADDR_W'({$urandom, $urandom});
      r.free_pages   = FCNT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick >= 50 && pick < 80 && live_runs.size() != 0) begin
         // Free a live run from any byte inside its first page; now and then
         // one page too many.
         j   = $urandom_range(0, live_runs.size() - 1);
         sel = live_runs[j];
         live_runs.delete(j);
         r.kind         = KIND_FREE;
         r.free_address = base_model
                          + ADDR_W'(sel.first * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
         r.free_pages   = FCNT_W'(sel.count + int'($urandom_range(0, 5) == 0));
      end else if (pick < 80) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
         r.byte_length = LEN_W'(n * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1));
      end else if (pick < 85) begin
         r.byte_length = '0;
      end else if (pick < 90) begin
         // Big runs: about half are at most the map size, the rest random lengths that mostly overflow it.
         if ($urandom_range(0, 1) == 0)
            r.byte_length = LEN_W'($urandom_range(1024, NUM_PAGES) * PAGE_BYTES);
      end else if (pick < 97) begin
         // Stray free around the map edges, partly below the base or past the end.
         r.kind         = KIND_FREE;
         r.free_address = base_model
                          + ADDR_W'($urandom_range(0, (NUM_PAGES + 16) * PAGE_BYTES))
                          - ADDR_W'(8 * PAGE_BYTES);
         r.free_pages   = FCNT_W'($urandom_range(0, 64));
      end else begin
         r.kind = KIND_FREE;
      end
      return r;
   endfunction

   // Present one transaction at a clock edge and hold it until accepted. Predict
   // at the accepting edge, then maybe drop valid for a short burst.
   task automatic issue(input request_type r, input bit typed, input result_type want);
      result_type model;
      req_valid        <= 1'b1;
      req_kind         <= r.kind;
      req_byte_length  <= r.byte_length;
      req_free_address <= r.free_address;
      req_free_pages   <= r.free_pages;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (r.kind == KIND_ALLOC)
         model = allocate_pages(r.byte_length);
      else
         model = release_pages(r.free_address, r.free_pages);
      pending_results.push_back(typed ? want : model);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4))
            @(posedge clock);
      end
   endtask

   // Write the region base only once every response is back and nothing is in work.
   task automatic write_region_base(input logic [ADDR_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      csr_valid       <= 1'b1;
      csr_region_base <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid  <= 1'b0;
      base_model  = value;
   endtask

   // Set a base, release the whole map as seen from that base, then run random traffic.
   task automatic run_phase(input logic [ADDR_W-1:0] base, input int items);
      request_type sweep;
      write_region_base(base);
      sweep.kind         = KIND_FREE;
      sweep.byte_length  = $urandom;
      sweep.free_address = base;
      sweep.free_pages   = FCNT_W'(NUM_PAGES);
      issue(sweep, 1'b0, '0);
      repeat (items)
         issue(random_request(), 1'b0, '0);
   endtask

   // Consume responses with bursts of stall, and check each against the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no transaction outstanding: status %0d, result_address %h",
                   rsp_status, rsp_result_address);
            failures++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status) begin
               $error("status mismatch: expected %0d, actual %0d", oldest.status, rsp_status);
               failures++;
            end
            if (rsp_result_address !== oldest.address) begin
               $error("result_address mismatch: expected %h, actual %h",
                      oldest.address, rsp_result_address);
               failures++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left  = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run when no transaction moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      base_model = '0;
      page_used  = '0;

      // Directed table, base zero, map empty. Typed rows are the obvious ones;
      // the rest go through the predictor.
      add_row(KIND_ALLOC, 32'd0, 48'd0, 13'd0, 1, STATUS_ZERO_LEN, 48'd0);
      add_row(KIND_ALLOC, 32'd1, 48'd0, 13'd0, 1, STATUS_OK, 48'h0);
      add_row(KIND_ALLOC, 32'd4096, 48'd0, 13'd0, 1, STATUS_OK, 48'h1000);
      add_row(KIND_ALLOC, 32'd4097, 48'd0, 13'd0, 1, STATUS_OK, 48'h2000);
      add_row(KIND_ALLOC, 32'hFFFF_FFFF, 48'd0, 13'd0, 1, STATUS_NO_FIT, 48'd0);
      add_row(KIND_ALLOC, 32'h0100_0001, 48'd0, 13'd0, 1, STATUS_NO_FIT, 48'd0);
      add_row(KIND_FREE, 32'd0, 48'h1000, 13'd1, 1, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'd100, 48'd0, 13'd0, 0, STATUS_OK, 48'd0);
      add_row(KIND_FREE, 32'd0, 48'd0, 13'd0, 1, STATUS_OK, 48'd0);
      // Page addresses wrap past the top of the address space onto pages 0 and 1.
      add_row(KIND_FREE, 32'd0, 48'hFFFF_FFFF_FFFF, 13'd3, 1, STATUS_OK, 48'd0);
      add_row(KIND_FREE, 32'd0, 48'd0, 13'h1FFF, 1, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'h0100_0000, 48'd0, 13'd0, 1, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'd1, 48'd0, 13'd0, 1, STATUS_NO_FIT, 48'd0);
      add_row(KIND_FREE, 32'd0, 48'h80_0000, 13'd1, 1, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'd8192, 48'd0, 13'd0, 0, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'd4096, 48'd0, 13'd0, 0, STATUS_OK, 48'd0);
      // Unaligned address inside page 2047; the tail past the map is ignored.
      add_row(KIND_FREE, 32'd0, 48'h7F_F123, 13'd4096, 1, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'hFFF, 48'hFFFF_FFFF_FFFF, 13'h1FFF, 0, STATUS_OK, 48'd0);
      add_row(KIND_FREE, 32'hFFFF_FFFF, 48'd0, 13'd2, 1, STATUS_OK, 48'd0);
      add_row(KIND_ALLOC, 32'hFFFF_F000, 48'd0, 13'd0, 1, STATUS_NO_FIT, 48'd0);
      add_row(KIND_FREE, 32'd0, 48'd0, 13'd4096, 1, STATUS_OK, 48'd0);

      repeat (11)
         @(posedge clock);
      reset <= 1'b0;

      // The block clears its map after reset; the first request waits it out through req_stall.
      write_region_base('0);
      foreach (directed_rows[i])
         issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // Base at the very top: result addresses wrap and most frees fall below the base.
      run_phase(48'hFFFF_FFFF_FFFF, 15);
      run_phase(ADDR_W'({$urandom, $urandom}) & ~ADDR_W'(PAGE_BYTES - 1), 40);
      run_phase(ADDR_W'({$urandom, $urandom}), 30);
      // Last stretch: back to base zero with both sides running flat out.
      quiet = 1'b1;
      run_phase('0, 40);

      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_seq.sv
rtl/core/bitmap_page_allocator.sv
rtl/core/bpa_checker.sv
tb/testbench.sv
